// ----- rtl/sil_pkg.sv -----
`timescale 1ns / 1ps

package sil_pkg;

  localparam int SIL_CAPACITY = 64;
  localparam int RIDX_W       = 10;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_UPDATE = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_RANGE     = 3'd3;
  localparam logic [2:0] STAT_DUP       = 3'd4;

  typedef struct packed {
    logic [2:0]        mode;
    logic [15:0]       handle;
    logic [47:0]       start_time;
    logic [47:0]       end_time;
    logic [RIDX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  position;
    logic [15:0] out_handle;
    logic [47:0] out_start;
    logic [47:0] out_end;
    logic [6:0]  count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [47:0] start_time;
    logic [47:0] end_time;
  } entry_t;

  typedef enum logic [1:0] {
    MV_NONE,
    MV_INSERT,
    MV_REMOVE,
    MV_UPDATE
  } move_t;

  typedef struct packed {
    logic  apply;
    move_t op;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic ahead;
    logic sel;
  } cell_flags_t;

endpackage

// ----- rtl/sil_cell.sv -----
`timescale 1ns / 1ps

module sil_cell #(
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  logic                        capture,
  input  sil_pkg::entry_t             probe,
  input  logic [sil_pkg::RIDX_W-1:0]  read_index,
  input  logic [CW-1:0]               count,
  input  sil_pkg::cell_ctl_t          ctl,
  input  logic [CW-1:0]               f_idx,
  input  logic [CW-1:0]               k_idx,
  input  sil_pkg::entry_t             new_ent,
  input  sil_pkg::entry_t             prev_ent,
  input  sil_pkg::entry_t             next_ent,
  input  logic                        prev_before,
  output sil_pkg::entry_t             ent,
  output sil_pkg::cell_flags_t        flags,
  output logic                        ins_mark
);
  import sil_pkg::*;

  localparam logic [CW-1:0]     MY_IDX    = CW'(INDEX);
  localparam logic [CW-1:0]     MY_IDX_P1 = CW'(INDEX + 1);
  localparam logic [RIDX_W-1:0] MY_RIDX   = RIDX_W'(INDEX);

  logic   occ;
  logic   key_before;
  entry_t ent_next;

  assign occ        = MY_IDX < count;
  assign key_before = (probe.start_time < ent.start_time) ||
                      ((probe.start_time == ent.start_time) &&
                       (probe.end_time > ent.end_time));

  always_ff @(posedge clk) begin
    if (capture) begin
      flags.match <= occ && (ent.handle == probe.handle);
      flags.ahead <= occ && key_before;
      flags.sel   <= occ && (read_index == MY_RIDX);
    end
  end

  // first cell whose key follows the new one
  assign ins_mark = flags.ahead && !prev_before;

  always_comb begin
    ent_next = ent;
    if (ctl.apply) begin
      unique case (ctl.op)
        MV_INSERT: begin
          if (MY_IDX == k_idx) begin
            ent_next = new_ent;
          end else if (MY_IDX > k_idx) begin
            ent_next = prev_ent;
          end
        end
        MV_REMOVE: begin
          if (MY_IDX >= f_idx) begin
            ent_next = next_ent;
          end
        end
        MV_UPDATE: begin
          if (f_idx < k_idx) begin
            if (MY_IDX_P1 == k_idx) begin
              ent_next = new_ent;
            end else if ((MY_IDX >= f_idx) && (MY_IDX_P1 < k_idx)) begin
              ent_next = next_ent;
            end
          end else begin
            if (MY_IDX == k_idx) begin
              ent_next = new_ent;
            end else if ((MY_IDX > k_idx) && (MY_IDX <= f_idx)) begin
              ent_next = prev_ent;
            end
          end
        end
        default: ent_next = ent;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// ----- rtl/sorted_interval_list.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake               payload
// request   in   req_valid / req_stall   req (mode, handle, times, index)
// response  out  rsp_valid / rsp_stall   rsp (status, position, entry, count)
//
// Each request is compared against every cell, then the row is shifted.
// One request in flight; req_stall is high in the execute phase, up to and including the shift.
// The shift waits while a previous response is stalled.
// Reset empties the list; cell contents are not cleared.

module sorted_interval_list #(
  parameter int CAPACITY = sil_pkg::SIL_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sil_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sil_pkg::rsp_t rsp
);
  import sil_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_EXEC = 2'b10
  } phase_t;

  phase_t        phase;
  req_t          req_q;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic accept;
  logic commit;

  entry_t      ent    [CAPACITY];
  entry_t      prev_e [CAPACITY];
  entry_t      next_e [CAPACITY];
  logic        prev_b [CAPACITY];
  cell_flags_t flags  [CAPACITY];

  logic [CAPACITY-1:0] match_v;
  logic [CAPACITY-1:0] mark_v;
  logic [CAPACITY-1:0] sel_v;

  entry_t        probe;
  entry_t        new_ent;
  cell_ctl_t     ctl;
  move_t         op;
  logic [CW-1:0] f_idx;
  logic [CW-1:0] k_enc;
  logic [CW-1:0] k_idx;
  logic          found;
  entry_t        rd;
  entry_t        rdata;
  logic [2:0]    status;
  logic [6:0]    pos;

  assign req_stall = (phase == PH_EXEC);
  assign accept    = req_valid && !req_stall;
  assign commit    = (phase == PH_EXEC) && (!rsp_valid || !rsp_stall);

  assign probe   = '{handle: req.handle, start_time: req.start_time,
                     end_time: req.end_time};
  assign new_ent = '{handle: req_q.handle, start_time: req_q.start_time,
                     end_time: req_q.end_time};
  assign ctl     = '{apply: commit, op: op};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign prev_e[gi] = '0;
        assign prev_b[gi] = 1'b0;
      end else begin : g_mid
        assign prev_e[gi] = ent[gi-1];
        assign prev_b[gi] = flags[gi-1].ahead;
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_e[gi] = '0;
      end else begin : g_inner
        assign next_e[gi] = ent[gi+1];
      end

      sil_cell #(
        .CW    (CW),
        .INDEX (gi)
      ) u_cell (
        .clk         (clk),
        .capture     (accept),
        .probe       (probe),
        .read_index  (req.read_index),
        .count       (count),
        .ctl         (ctl),
        .f_idx       (f_idx),
        .k_idx       (k_idx),
        .new_ent     (new_ent),
        .prev_ent    (prev_e[gi]),
        .next_ent    (next_e[gi]),
        .prev_before (prev_b[gi]),
        .ent         (ent[gi]),
        .flags       (flags[gi]),
        .ins_mark    (mark_v[gi])
      );

      assign match_v[gi] = flags[gi].match;
      assign sel_v[gi]   = flags[gi].sel;
    end
  endgenerate

  // one-hot to index, and read select
  always_comb begin
    f_idx = '0;
    k_enc = '0;
    rd    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_v[i]) begin
        f_idx = f_idx | CW'(i);
      end
      if (mark_v[i]) begin
        k_enc = k_enc | CW'(i);
      end
      if (sel_v[i]) begin
        rd = rd | ent[i];
      end
    end
  end

  assign found = |match_v;
  assign k_idx = (|mark_v) ? k_enc : count;

  always_comb begin
    op         = MV_NONE;
    status     = STAT_OK;
    pos        = '0;
    count_next = count;
    rdata      = '0;
    unique case (req_q.mode)
      MODE_INSERT: begin
        if (found) begin
          status = STAT_DUP;
          pos    = 7'(f_idx);
        end else if (count == CW'(CAPACITY)) begin
          status = STAT_FULL;
        end else begin
          op         = MV_INSERT;
          pos        = 7'(k_idx);
          count_next = CW'(count + 1'b1);
        end
      end
      MODE_REMOVE: begin
        if (found) begin
          op         = MV_REMOVE;
          pos        = 7'(f_idx);
          count_next = CW'(count - 1'b1);
        end else begin
          status = STAT_NOT_FOUND;
        end
      end
      MODE_UPDATE: begin
        if (found) begin
          op  = MV_UPDATE;
          pos = (f_idx < k_idx) ? 7'(k_idx - 1'b1) : 7'(k_idx);
        end else begin
          status = STAT_NOT_FOUND;
        end
      end
      MODE_READ: begin
        if (|sel_v) begin
          pos   = 7'(req_q.read_index);
          rdata = rd;
        end else begin
          status = STAT_RANGE;
        end
      end
      MODE_CLEAR: begin
        count_next = '0;
      end
      default: begin
        op = MV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (req_valid) begin
            phase <= PH_EXEC;
          end
        end
        PH_EXEC: begin
          if (commit) begin
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
      if (commit) begin
        rsp_valid <= 1'b1;
        count     <= count_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (commit) begin
      rsp <= '{status: status, position: pos, out_handle: rdata.handle,
               out_start: rdata.start_time, out_end: rdata.end_time,
               count: 7'(count_next)};
    end
  end

endmodule

// ----- rtl/sil_check.sv -----
`timescale 1ns / 1ps

module sil_check (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input sil_pkg::rsp_t rsp
);
  import sil_pkg::*;

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != STAT_OK) |->
      (rsp.out_handle == '0) && (rsp.out_start == '0) && (rsp.out_end == '0) &&
      ((rsp.status == STAT_DUP) || (rsp.position == '0)))
    else $error("failed request carries data");

  a_free_after_rsp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !req_stall)
    else $error("block busy after issuing response");

endmodule

bind sorted_interval_list sil_check u_sil_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- bench/sil_checker.sv -----
`timescale 1ns / 1ps

module sil_checker
  import sil_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fails,
  output int   outstanding
);

  entry_t rows [SIL_CAPACITY];
  int     held = 0;
  rsp_t   answers_due [$];
  int     nerr = 0;

  function automatic int locate(logic [15:0] h);
    for (int i = 0; i < held; i++)
      if (rows[i].handle == h) return i;
    return held;
  endfunction

  function automatic bit goes_ahead(logic [47:0] s, logic [47:0] e, entry_t x);
    return (s < x.start_time) || (s == x.start_time && e > x.end_time);
  endfunction

  function automatic void drop_at(int p);
    for (int i = p; i + 1 < held; i++)
      rows[i] = rows[i + 1];
    held--;
  endfunction

  function automatic int place(logic [15:0] h, logic [47:0] s, logic [47:0] e);
    int p;
    p = 0;
    while (p < held && !goes_ahead(s, e, rows[p]))
      p++;
    for (int i = held; i > p; i--)
      rows[i] = rows[i - 1];
    rows[p].handle     = h;
    rows[p].start_time = s;
    rows[p].end_time   = e;
    held++;
    return p;
  endfunction

  // applies one request to the shadow list and returns its answer
  function automatic rsp_t apply_req(req_t r);
    rsp_t o;
    int   f;
    int   p;
    o = '0;
    f = locate(r.handle);
    case (r.mode)
      MODE_INSERT: begin
        if (f < held) begin
          o.status   = STAT_DUP;
          o.position = f[6:0];
        end else if (held >= SIL_CAPACITY) begin
          o.status = STAT_FULL;
        end else begin
          p = place(r.handle, r.start_time, r.end_time);
          o.position = p[6:0];
        end
      end
      MODE_REMOVE: begin
        if (f < held) begin
          o.position = f[6:0];
          drop_at(f);
        end else begin
          o.status = STAT_NOT_FOUND;
        end
      end
      MODE_UPDATE: begin
        if (f < held) begin
          drop_at(f);
          p = place(r.handle, r.start_time, r.end_time);
          o.position = p[6:0];
        end else begin
          o.status = STAT_NOT_FOUND;
        end
      end
      MODE_READ: begin
        if (r.read_index < held && r.read_index < SIL_CAPACITY) begin
          o.position   = r.read_index[6:0];
          o.out_handle = rows[r.read_index].handle;
          o.out_start  = rows[r.read_index].start_time;
          o.out_end    = rows[r.read_index].end_time;
        end else begin
          o.status = STAT_RANGE;
        end
      end
      MODE_CLEAR: held = 0;
      default: ;
    endcase
    o.count = held[6:0];
    return o;
  endfunction

  function automatic int field_bad(string name, logic [47:0] want, logic [47:0] got);
    if (want === got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      held = 0;
      answers_due.delete();
    end else begin
      if (req_valid && !req_stall) answers_due.push_back(apply_req(req));
      if (rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          $error("response with no request outstanding");
          nerr++;
        end else begin
          want = answers_due.pop_front();
          nerr += field_bad("status", 48'(want.status), 48'(rsp.status));
          nerr += field_bad("position", 48'(want.position), 48'(rsp.position));
          nerr += field_bad("out_handle", 48'(want.out_handle), 48'(rsp.out_handle));
          nerr += field_bad("out_start", want.out_start, rsp.out_start);
          nerr += field_bad("out_end", want.out_end, rsp.out_end);
          nerr += field_bad("count", 48'(want.count), 48'(rsp.count));
        end
      end
    end
    fails       <= nerr;
    outstanding <= answers_due.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sil_pkg::*;

  typedef enum int {PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH} pace_t;
  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

  localparam logic [47:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int          PHASES   = 8;
  localparam int          PER_PHASE = 225;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;
  int    fails;
  int    outstanding;
  pace_t pace = PACE_FREE;
  logic  long_hold_req = 1'b0;

  logic [15:0] handle_pool [96];
  logic [47:0] tick_pool [16];

  pace_t pace_seq [PHASES] = '{PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH,
                               PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH};
  mix_t  mix_seq [PHASES]  = '{MIX_FILL, MIX_CHURN, MIX_FILL, MIX_DRAIN,
                               MIX_CHURN, MIX_FILL, MIX_DRAIN, MIX_CHURN};

  always #1 clk = ~clk;

  sorted_interval_list dut (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
  );

  sil_checker chk (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .fails, .outstanding
  );

  initial begin
    #1_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic req_t cmd(logic [2:0] m, logic [15:0] h, logic [47:0] s,
                               logic [47:0] e, logic [9:0] idx);
    req_t r;
    r.mode       = m;
    r.handle     = h;
    r.start_time = s;
    r.end_time   = e;
    r.read_index = idx;
    return r;
  endfunction

  // small values and a shared pool give many equal keys
  function automatic logic [47:0] pick_tick();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 48'($urandom_range(15));
    if (roll < 80) return tick_pool[$urandom_range(15)];
    if (roll < 90) return {16'($urandom), 32'($urandom)};
    return $urandom_range(1) ? TICK_MAX : 48'h0;
  endfunction

  function automatic req_t make_req(mix_t m);
    req_t r;
    int   roll;
    int   cut [5];
    case (m)
      MIX_FILL:  cut = '{58, 65, 77, 97, 97};
      MIX_CHURN: cut = '{30, 50, 70, 93, 94};
      default:   cut = '{15, 50, 62, 94, 95};
    endcase
    r.handle     = ($urandom_range(9) == 0) ? 16'($urandom)
                                            : handle_pool[$urandom_range(95)];
    r.start_time = pick_tick();
    r.end_time   = pick_tick();
    r.read_index = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(70));
    roll = $urandom_range(99);
    if (roll < cut[0])      r.mode = MODE_INSERT;
    else if (roll < cut[1]) r.mode = MODE_REMOVE;
    else if (roll < cut[2]) r.mode = MODE_UPDATE;
    else if (roll < cut[3]) r.mode = MODE_READ;
    else if (roll < cut[4]) r.mode = MODE_CLEAR;
    else                    r.mode = MODE_CLEAR + 3'($urandom_range(1, 3));
    return r;
  endfunction

  function automatic bit src_idles();
    case (pace)
      PACE_SRC:  return $urandom_range(99) < 45;
      PACE_BOTH: return $urandom_range(99) < 6;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic issue(input req_t r);
    while (src_idles()) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_all_answered();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : sink
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (pace)
          PACE_SNK:  rsp_stall <= ($urandom_range(99) < 45);
          PACE_BOTH: rsp_stall <= ($urandom_range(99) < 6);
          default:   rsp_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    for (int i = 0; i < 96; i++) handle_pool[i] = 16'($urandom);
    handle_pool[0] = 16'h0000;
    handle_pool[1] = 16'hFFFF;
    for (int i = 0; i < 16; i++) tick_pool[i] = {16'($urandom), 32'($urandom)};
    tick_pool[0] = 48'h0;
    tick_pool[1] = TICK_MAX;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty list, absent handles, equal keys, duplicate, moves, bounds
    issue(cmd(MODE_READ, 16'h0, 48'h0, 48'h0, 10'd0));
    issue(cmd(MODE_REMOVE, 16'd7, 48'h0, 48'h0, 10'd0));
    issue(cmd(MODE_UPDATE, 16'd7, 48'd3, 48'd4, 10'd0));
    issue(cmd(MODE_INSERT, 16'h0000, TICK_MAX, TICK_MAX, 10'd0));
    issue(cmd(MODE_INSERT, 16'hFFFF, 48'h0, 48'h0, 10'd0));
    issue(cmd(MODE_INSERT, 16'd1, 48'd5, 48'd10, 10'd0));
    issue(cmd(MODE_INSERT, 16'd2, 48'd5, 48'd20, 10'd0));
    issue(cmd(MODE_INSERT, 16'd3, 48'd5, 48'd10, 10'd0));
    issue(cmd(MODE_INSERT, 16'd1, 48'h0, 48'h0, 10'd0));
    issue(cmd(MODE_UPDATE, 16'd3, 48'h0, TICK_MAX, 10'd0));
    issue(cmd(MODE_UPDATE, 16'h0000, TICK_MAX, TICK_MAX, 10'd0));
    for (int i = 0; i < 6; i++) issue(cmd(MODE_READ, 16'h0, 48'h0, 48'h0, 10'(i)));
    issue(cmd(MODE_READ, 16'hFFFF, TICK_MAX, TICK_MAX, 10'h3FF));
    issue(cmd(MODE_REMOVE, 16'd2, 48'h0, 48'h0, 10'd0));
    issue(cmd(MODE_REMOVE, 16'd2, 48'h0, 48'h0, 10'd0));
    for (int k = 1; k <= 3; k++)
      issue(cmd(MODE_CLEAR + 3'(k), 16'hFFFF, TICK_MAX, TICK_MAX, 10'h3FF));
    issue(cmd(MODE_CLEAR, 16'h0, 48'h0, 48'h0, 10'd0));
    issue(cmd(MODE_READ, 16'h0, 48'h0, 48'h0, 10'd0));
    wait_all_answered();

    for (int ph = 0; ph < PHASES; ph++) begin
      pace = pace_seq[ph];
      if (ph == 2) long_hold_req = 1'b1;
      repeat (PER_PHASE) issue(make_req(mix_seq[ph]));
      wait_all_answered();
    end

    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sorted_interval_list.f -----
rtl/sil_pkg.sv
rtl/sil_cell.sv
rtl/sorted_interval_list.sv
rtl/sil_check.sv
bench/sil_checker.sv
bench/tb_top.sv
